// ===== sv/rotary_position_embedding_rotate_defines.svh =====
// Assertion macros for the rotary position embedding rotate block.
`ifndef ROTARY_POSITION_EMBEDDING_ROTATE_DEFINES_SVH
`define ROTARY_POSITION_EMBEDDING_ROTATE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is applied
`define RPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define RPR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPR_ASSERT(lbl, prop, msg)
`define RPR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/rope_pkg.sv =====
// Shared types, constants and frequency table helpers for the rotary embedding block.
package rope_pkg;

	localparam int unsigned XW     = 32;
	localparam int unsigned POS_W  = 15;
	localparam int unsigned PAIR_W = 7;
	localparam int unsigned ANG_W  = 32;
	// fraction guard bits kept through the rotation
	localparam int unsigned GUARD  = 20;
	// datapath width: scaled input (~2^50.3) times CORDIC growth and sqrt(2), plus sign
	localparam int unsigned CORD_W = 54;
	localparam int unsigned ROM_DEPTH = 2 ** PAIR_W;

	// CORDIC gain compensation, UQ0.32
	localparam logic [31:0] GAIN_Q32     = 32'd2608131496;
	// 1/(2*pi) in turns, UQ0.32
	localparam logic [63:0] INV_2PI_Q32  = 64'd683565276;
	// log2(1e8) in Q.32
	localparam logic [63:0] LOG2_1E8_Q32 = 64'd114140580218;

	localparam logic signed [CORD_W-1:0] RND_HALF = CORD_W'(64'd1 << (GUARD - 1));
	localparam logic signed [CORD_W-1:0] SAT_HI   = CORD_W'(64'h7FFF_FFFF);
	localparam logic signed [CORD_W-1:0] SAT_LO   = ~SAT_HI;
	localparam logic signed [ANG_W-1:0]  Z_LIM    = 32'sd536870912;

	// arctangent of 2^-i in turns, UQ0.32
	localparam logic signed [ANG_W-1:0] ATAN_TURNS [32] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81,
		32'sd41,        32'sd20,        32'sd10,        32'sd5,
		32'sd3,         32'sd1,         32'sd1,         32'sd0
	};

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} quad_t;

	// one CORDIC stage's payload
	typedef struct packed {
		logic                     pass;
		logic signed [CORD_W-1:0] x;
		logic signed [CORD_W-1:0] y;
		logic signed [ANG_W-1:0]  z;
	} cord_t;

	// floor square root, digit by digit
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] r;
		logic [63:0] b;
		rem = v;
		r   = '0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// frequency in turns per position from a Q.32 log2 exponent
	function automatic logic [31:0] freq_from_exp(input logic [63:0] e);
		logic [63:0] s;
		logic [63:0] f;
		logic [31:0] n;
		s = 64'd1 << 31;
		f = INV_2PI_Q32;
		n = e[63:32];
		for (int k = 1; k <= 32; k++) begin
			s = isqrt64(s << 32);
			if (e[32-k])
				f = (f * s) >> 32;
		end
		return (n < 32'd64) ? 32'(f >> n[5:0]) : 32'd0;
	endfunction

endpackage

// ===== sv/rope_cordic_stage.sv =====
// One registered CORDIC rotation step with a fixed shift.
module rope_cordic_stage #(
	parameter int unsigned SHIFT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  rope_pkg::cord_t d_in,
	output logic           vld_out,
	output rope_pkg::cord_t d_out
);
	import rope_pkg::*;

	localparam logic signed [ANG_W-1:0] ATAN = ATAN_TURNS[SHIFT];

	logic  v_s;
	cord_t d_s;
	cord_t nxt;

	// rotate toward zero residual; pass-through items hold
	always_comb begin
		nxt = d_in;
		if (!d_in.pass) begin
			if (d_in.z >= 0) begin
				nxt.x = d_in.x - (d_in.y >>> SHIFT);
				nxt.y = d_in.y + (d_in.x >>> SHIFT);
				nxt.z = d_in.z - ATAN;
			end else begin
				nxt.x = d_in.x + (d_in.y >>> SHIFT);
				nxt.y = d_in.y - (d_in.x >>> SHIFT);
				nxt.z = d_in.z + ATAN;
			end
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= 1'b0;
		end else if (en) begin
			v_s <= vld_in;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			d_s <= nxt;
		end
	end

	assign vld_out = v_s;
	assign d_out   = d_s;

endmodule

// ===== sv/rotary_position_embedding_rotate.sv =====
// Channel   | Dir | Sideband                         | Payload
// s_axis    | in  | tvalid, tready                   | tdata[87:0]: x_even, x_odd, position, pair_index
// m_axis    | out | tvalid, tready, tuser(saturated) | tdata[63:0]: y_even, y_odd
//
// Fully pipelined: one pair per cycle while m_axis does not stall; stages in order
// are input/ROM read, multiply, quadrant fold, one CORDIC step per stage, round/clamp.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on m_axis freezes every stage at once; s_axis_tready follows
// m_axis_tready whenever the output register holds a result.
`include "rotary_position_embedding_rotate_defines.svh"

module rotary_position_embedding_rotate #(
	parameter int unsigned ROT_SPAN     = 128,
	parameter int unsigned HEAD_SPAN    = 128,
	parameter int unsigned MAX_POSITION = 32768,
	parameter int unsigned CORDIC_STEPS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] x_even, [63:32] x_odd, [78:64] position, [85:79] pair_index, [87:86] zero
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] y_even, [63:32] y_odd
	output logic [63:0] m_axis_tdata,
	// [0] saturated
	output logic        m_axis_tuser
);
	import rope_pkg::*;

	localparam int unsigned ROT_PAIRS =
		((ROT_SPAN < HEAD_SPAN) ? ROT_SPAN : HEAD_SPAN) / 2;
	localparam int unsigned POS_CMP_W = 21;

	// frequency table, turns per position in UQ0.32
	logic [31:0] freq_rom [ROM_DEPTH];

	for (genvar j = 0; j < ROM_DEPTH; j++) begin : g_rom
		localparam logic [63:0] EXP_Q32 = (64'(j) * LOG2_1E8_Q32) / 64'(ROT_SPAN);
		assign freq_rom[j] = (j < ROT_PAIRS) ? freq_from_exp(EXP_Q32) : 32'd0;
	end

	logic pipe_en;

	// input field split
	logic signed [XW-1:0] in_xe;
	logic signed [XW-1:0] in_xo;
	logic [POS_W-1:0]     in_pos;
	logic [PAIR_W-1:0]    in_pair;
	logic [POS_W-1:0]     pos_clamped;
	logic                 in_pass;

	assign in_xe   = s_axis_tdata[31:0];
	assign in_xo   = s_axis_tdata[63:32];
	assign in_pos  = s_axis_tdata[78:64];
	assign in_pair = s_axis_tdata[85:79];

	assign in_pass = ({1'b0, in_pair} >= (PAIR_W + 1)'(ROT_PAIRS));

	// clamp position into the table range
	always_comb begin
		pos_clamped = in_pos;
		if (POS_CMP_W'(in_pos) >= POS_CMP_W'(MAX_POSITION))
			pos_clamped = POS_W'(MAX_POSITION - 1);
	end

	// stage 1: capture and frequency lookup
	logic                 vld_s1;
	logic                 pass_s1;
	logic signed [XW-1:0] xe_s1;
	logic signed [XW-1:0] xo_s1;
	logic [POS_W-1:0]     pos_s1;
	logic [31:0]          freq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pass_s1 <= in_pass;
			xe_s1   <= in_xe;
			xo_s1   <= in_xo;
			pos_s1  <= pos_clamped;
			freq_s1 <= freq_rom[in_pair];
		end
	end

	// stage 2: phase product and gain scaling
	logic               vld_s2;
	logic               pass_s2;
	logic [ANG_W-1:0]   phase_s2;
	logic signed [64:0] px_s2;
	logic signed [64:0] py_s2;
	logic signed [64:0] gx;
	logic signed [64:0] gy;

	always_comb begin
		if (pass_s1) begin
			// shifted so that the later >>> 12 leaves x << GUARD exactly
			gx = {xe_s1[XW-1], xe_s1, 32'd0};
			gy = {xo_s1[XW-1], xo_s1, 32'd0};
		end else begin
			gx = xe_s1 * $signed({1'b0, GAIN_Q32});
			gy = xo_s1 * $signed({1'b0, GAIN_Q32});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (pipe_en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pass_s2  <= pass_s1;
			phase_s2 <= ANG_W'(pos_s1 * freq_s1);
			px_s2    <= gx;
			py_s2    <= gy;
		end
	end

	// stage 3: quadrant fold and residual angle
	logic                     vld_s3;
	cord_t                    c3_s3;
	cord_t                    c3_nxt;
	logic [ANG_W-1:0]         phase_rnd;
	quad_t                    quad;
	logic signed [CORD_W-1:0] sx;
	logic signed [CORD_W-1:0] sy;

	always_comb begin
		phase_rnd   = phase_s2 + 32'h2000_0000;
		quad        = quad_t'(phase_rnd[31:30]);
		sx          = CORD_W'(px_s2 >>> (32 - GUARD));
		sy          = CORD_W'(py_s2 >>> (32 - GUARD));
		c3_nxt.pass = pass_s2;
		c3_nxt.z    = $signed(phase_s2 - {phase_rnd[31:30], 30'd0});
		unique case (quad)
			QUAD_0: begin
				c3_nxt.x = sx;
				c3_nxt.y = sy;
			end
			QUAD_90: begin
				c3_nxt.x = -sy;
				c3_nxt.y = sx;
			end
			QUAD_180: begin
				c3_nxt.x = -sx;
				c3_nxt.y = -sy;
			end
			QUAD_270: begin
				c3_nxt.x = sy;
				c3_nxt.y = -sx;
			end
			default: begin
				c3_nxt.x = sx;
				c3_nxt.y = sy;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (pipe_en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			c3_s3 <= c3_nxt;
		end
	end

	// CORDIC chain, one step per stage
	logic  cord_v [CORDIC_STEPS+1];
	cord_t cord_d [CORDIC_STEPS+1];

	assign cord_v[0] = vld_s3;
	assign cord_d[0] = c3_s3;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		rope_cordic_stage #(
			.SHIFT(i)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (pipe_en),
			.vld_in (cord_v[i]),
			.d_in   (cord_d[i]),
			.vld_out(cord_v[i+1]),
			.d_out  (cord_d[i+1])
		);
	end

	// final stage: round half up and saturate
	logic                     out_vld_q;
	logic                     out_pass_q;
	logic [XW-1:0]            ye_q;
	logic [XW-1:0]            yo_q;
	logic                     sat_q;
	logic signed [CORD_W-1:0] rx;
	logic signed [CORD_W-1:0] ry;
	logic [XW-1:0]            cx;
	logic [XW-1:0]            cy;
	logic                     sat_x;
	logic                     sat_y;

	always_comb begin
		rx    = (cord_d[CORDIC_STEPS].x + RND_HALF) >>> GUARD;
		ry    = (cord_d[CORDIC_STEPS].y + RND_HALF) >>> GUARD;
		sat_x = (rx > SAT_HI) || (rx < SAT_LO);
		sat_y = (ry > SAT_HI) || (ry < SAT_LO);
		cx    = (rx > SAT_HI) ? SAT_HI[XW-1:0] : ((rx < SAT_LO) ? SAT_LO[XW-1:0] : rx[XW-1:0]);
		cy    = (ry > SAT_HI) ? SAT_HI[XW-1:0] : ((ry < SAT_LO) ? SAT_LO[XW-1:0] : ry[XW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pipe_en) begin
			out_vld_q <= cord_v[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			out_pass_q <= cord_d[CORDIC_STEPS].pass;
			ye_q       <= cx;
			yo_q       <= cy;
			sat_q      <= sat_x | sat_y;
		end
	end

	// whole pipeline moves unless a held result is refused
	assign pipe_en       = m_axis_tready | ~out_vld_q;
	assign s_axis_tready = pipe_en;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {yo_q, ye_q};
	assign m_axis_tuser  = sat_q;

	// checks
	`RPR_ASSERT(a_stall_freeze, !pipe_en |=> $stable(vld_s1) && $stable(vld_s3) && $stable(out_vld_q), "pipeline moved while stalled")
	`RPR_ASSERT(a_resid_range, vld_s3 |-> (c3_s3.z >= -Z_LIM) && (c3_s3.z < Z_LIM), "residual angle outside quarter turn")
	`RPR_ASSERT(a_pass_nosat, out_vld_q && out_pass_q |-> !sat_q, "pass-through pair flagged saturated")

endmodule
